>>> rtl/sfm_pkg.sv
// Shared types, constants and the case fold function for the substring search block.
package sfm_pkg;

    localparam int NEEDLE_MAX_DEF = 16;
    localparam int CHAR_BITS_DEF  = 16;
    localparam int POS_BITS_DEF   = 16;

    localparam int CHAR_W   = 16;
    localparam int INDEX_W  = 4;
    localparam int POS_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;
    localparam int LEN_CFG_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_EXACT_CMP     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 4'd1;

    localparam logic FUNC_NEEDLE_WRITE = 1'b0;
    localparam logic FUNC_HAYSTACK     = 1'b1;

    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 16'h0041;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 16'h005A;
    localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 16'h0020;

    typedef struct packed {
        logic              func;
        logic [INDEX_W-1:0] entry_index;
        logic [CHAR_W-1:0] char_value;
        logic              first_char;
        logic              last_char;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } t_result;

    // Fold ASCII upper case to lower when the compare is case insensitive.
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic exact);
        logic [CHAR_W-1:0] r;
        r = c;
        if (!exact && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            r = c + ASCII_CASE_OFS;
        end
        return r;
    endfunction

endpackage

>>> rtl/sfm_matcher.sv
// Needle store, recent character window, position counter and parallel window compare.
module sfm_matcher #(
    parameter int NEEDLE_MAX = sfm_pkg::NEEDLE_MAX_DEF,
    parameter int CHAR_BITS  = sfm_pkg::CHAR_BITS_DEF,
    parameter int POS_BITS   = sfm_pkg::POS_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  sfm_pkg::t_item                 i_item,
    input  logic                           i_exact_cmp,
    input  logic [sfm_pkg::LEN_CFG_W-1:0]  i_needle_length,
    output logic                           o_res_valid,
    output sfm_pkg::t_result               o_res
);

    localparam int NIDX    = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int LEN_BITS = $clog2(NEEDLE_MAX + 1);
    localparam int CW      = (LEN_BITS > sfm_pkg::LEN_CFG_W) ? LEN_BITS : sfm_pkg::LEN_CFG_W;
    localparam int CNT_W   = POS_BITS + 1;
    localparam logic [CNT_W-1:0]    COUNT_SAT = {1'b1, {POS_BITS{1'b0}}};
    localparam logic [POS_BITS-1:0] POS_MAX   = {POS_BITS{1'b1}};

    logic [CHAR_BITS-1:0] r_needle [NEEDLE_MAX];
    logic [CNT_W-1:0]     r_count;
    logic                 r_done;

    logic [CHAR_BITS-1:0] c;
    logic [CHAR_BITS-1:0] w [NEEDLE_MAX];
    logic                 is_hay;
    logic                 active;
    logic [CW-1:0]        len_wide;
    logic [LEN_BITS-1:0]  len;
    logic [CNT_W-1:0]     n_count;
    logic                 n_done;
    logic                 hit;
    logic [POS_BITS-1:0]  pos;
    logic                 shift_en;

    assign c      = i_item.char_value[CHAR_BITS-1:0];
    assign is_hay = (i_item.func == sfm_pkg::FUNC_HAYSTACK);
    assign active = is_hay && (i_item.first_char || !r_done);

    // Clamp the configured length to the needle capacity.
    always_comb begin
        len_wide = CW'(i_needle_length);
        if (len_wide > CW'(NEEDLE_MAX)) begin
            len_wide = CW'(NEEDLE_MAX);
        end
        len = LEN_BITS'(len_wide);
    end

    // Window: the current character, then older characters; a new search sees zeros.
    assign w[0] = c;
    generate
        if (NEEDLE_MAX > 1) begin : g_hist
            logic [CHAR_BITS-1:0] r_recent [NEEDLE_MAX-1];
            for (genvar k = 1; k < NEEDLE_MAX; k++) begin : g_win
                assign w[k] = i_item.first_char ? '0 : r_recent[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int k = 0; k < NEEDLE_MAX - 1; k++) begin
                        r_recent[k] <= '0;
                    end
                end else if (shift_en) begin
                    for (int k = 0; k < NEEDLE_MAX - 1; k++) begin
                        r_recent[k] <= w[k];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        logic [LEN_BITS-1:0] back;
        hit = (n_count >= CNT_W'(len));
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            back = len - LEN_BITS'(1) - LEN_BITS'(i);
            if (LEN_BITS'(i) < len) begin
                if (sfm_pkg::fold_char(sfm_pkg::CHAR_W'(w[back[NIDX-1:0]]), i_exact_cmp)
                    != sfm_pkg::fold_char(sfm_pkg::CHAR_W'(r_needle[i]), i_exact_cmp))
                begin
                    hit = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (i_item.first_char) begin
            n_count = CNT_W'(1);
        end else if (r_count == COUNT_SAT) begin
            n_count = r_count;
        end else begin
            n_count = r_count + CNT_W'(1);
        end
        if (n_count[POS_BITS]) begin
            pos = POS_MAX;
        end else begin
            pos = POS_BITS'(n_count - CNT_W'(len));
        end
    end

    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        n_done      = r_done;
        shift_en    = 1'b0;
        if (active) begin
            n_done = 1'b0;
            if (len == '0) begin
                o_res_valid = 1'b1;
                o_res.found = 1'b1;
                n_done      = 1'b1;
            end else begin
                shift_en = i_fire;
                if (hit) begin
                    o_res_valid          = 1'b1;
                    o_res.found          = 1'b1;
                    o_res.match_position = sfm_pkg::POS_W'(pos);
                    n_done               = 1'b1;
                end else if (i_item.last_char) begin
                    o_res_valid = 1'b1;
                    n_done      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b1;
        end else if (i_fire && active) begin
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Needle entries hold no reset; writes past the capacity drop.
    always_ff @(posedge i_clk) begin
        if (i_fire && !is_hay && (32'(i_item.entry_index) < NEEDLE_MAX)) begin
            r_needle[NIDX'(32'(i_item.entry_index))] <= c;
        end
    end

endmodule

>>> rtl/substring_first_match.sv
// Top level of the streaming first-match substring search with handshake registers.
//
//  channel | direction | handshake                       | payload
//  --------+-----------+---------------------------------+--------------------------------
//  in      | to block  | i_in_valid / o_in_stall         | func, entry_index, char_value,
//          |           |                                 | first_char, last_char
//  out     | from block| o_out_valid / i_out_stall       | found, match_position
//  cfg     | to block  | i_cfg_we, i_cfg_index           | i_cfg_data
//
// One item per cycle sustained while the result side does not stall; an accepted item is held in
// the input register, then the window compare against all needle entries in parallel writes
// the result register, from which the result can be taken. Synchronous active-low reset
// resets the search state (no search active), the configuration and the valid flags of both
// registers; needle entries and the held item and result are not cleared.
// A stall on the result side holds the result register and then the input register;
// the input side stalls only when both are full.
module substring_first_match #(
    parameter int NEEDLE_MAX = sfm_pkg::NEEDLE_MAX_DEF,
    parameter int CHAR_BITS  = sfm_pkg::CHAR_BITS_DEF,
    parameter int POS_BITS   = sfm_pkg::POS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_func,
    input  logic [sfm_pkg::INDEX_W-1:0]     i_entry_index,
    input  logic [sfm_pkg::CHAR_W-1:0]      i_char_value,
    input  logic                            i_first_char,
    input  logic                            i_last_char,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_found,
    output logic [sfm_pkg::POS_W-1:0]       o_match_position,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [sfm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                             r_exact_cmp;
    logic [sfm_pkg::LEN_CFG_W-1:0]    r_needle_length;

    logic                             r_s1_valid;
    sfm_pkg::t_item                   r_s1_item;
    logic                             r_out_valid;
    sfm_pkg::t_result                 r_out;

    logic                             advance;
    logic                             in_take;
    logic                             fire;
    logic                             res_valid;
    sfm_pkg::t_result                 res;

    // Advance the pipe when the result register is empty or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign fire       = r_s1_valid && advance;

    // Configuration registers; drop writes to unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact_cmp     <= 1'b1;
            r_needle_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfm_pkg::CFG_EXACT_CMP:     r_exact_cmp     <= i_cfg_data[0];
                sfm_pkg::CFG_NEEDLE_LENGTH: r_needle_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: hold while stalled, load on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.func        <= i_func;
            r_s1_item.entry_index <= i_entry_index;
            r_s1_item.char_value  <= i_char_value;
            r_s1_item.first_char  <= i_first_char;
            r_s1_item.last_char   <= i_last_char;
        end
    end

    sfm_matcher #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .CHAR_BITS  (CHAR_BITS),
        .POS_BITS   (POS_BITS)
    ) u_matcher (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_item           (r_s1_item),
        .i_exact_cmp      (r_exact_cmp),
        .i_needle_length  (r_needle_length),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    // Result register: load a result when the item completes, clear once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_out.found;
    assign o_match_position = r_out.match_position;

endmodule
